// ===== hdl/dstq_pkg.sv =====
package dstq_pkg;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [19:0] USEC_MAX     = 20'd999999;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_FIRED  = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_LIST   = 3'd3,
        KIND_REPORT = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_FULL = 2'd1,
        ERR_BAD  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_SCHEDULED = 2'd0,
        ST_NEXT      = 2'd1,
        ST_DONE      = 2'd2
    } entry_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_FIND,
        S_INS_SHIFT,
        S_INS_ARM,
        S_REM_FIND,
        S_REM_SHIFT,
        S_TICK_SCAN,
        S_TICK_SHIFT,
        S_TICK_ARM,
        S_LIST,
        S_OUT
    } state_t;

endpackage

// ===== hdl/deadline_sorted_timer_queue.sv =====
// Deadline-sorted timer event queue.
// The s_ channel takes one command word: tick, insert, remove or list. The
// m_ channel returns result words; m_tlast marks the final word of a command.
// Insert and remove give one word, tick gives one word per fired event and
// a next-deadline report, list gives one word per entry (none when empty).
// Two comparators (against the new deadline and against now) and a single
// order-list write port walk the sorted entries one position per cycle, while
// the output is not stalled. An insert finds its place, shifts later entries
// up and scans for the entry to arm; a remove finds the entry and shifts later
// entries down. A tick scans, unlinks each freed event, then seeks the report.
// A list gives one word per cycle unless stalled. s_tready is high only while
// the block is idle and no result word is waiting, so commands never overlap.
// Each result word is held in an output register; when the receiver stalls,
// the walk pauses until the word is taken. Reset frees every slot, empties
// the list and clears the armed entry; no clearing pass is needed.
module deadline_sorted_timer_queue
    import dstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], now_sec[33:2], now_usec[53:34], delay_sec[85:54],
    // delay_usec[105:86], user_tag[121:106], target_handle[125:122]
    input  logic [127:0] s_tdata,
    // remove_after_fire
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // handle[3:0], error_code[5:4], entry_state[7:6], tag[23:8],
    // deadline_sec[55:24], deadline_usec[75:56], timer_armed[76]
    output logic [79:0]  m_tdata,
    // kind
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [31:0] sec_mem [QUEUE_DEPTH];
    logic [19:0] usec_mem [QUEUE_DEPTH];
    logic [15:0] tag_mem [QUEUE_DEPTH];
    logic [SW-1:0] order_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] used_reg, done_reg, rmv_reg;
    logic [QUEUE_DEPTH-1:0] used_next, done_next, rmv_next;

    logic [CW-1:0] count_reg, count_next;
    logic          armed_reg, armed_next;
    logic [SW-1:0] armed_slot_reg, armed_slot_next;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [31:0] nsec_reg, nsec_next, dsec_reg, dsec_next;
    logic [19:0] nusec_reg, nusec_next, dusec_reg, dusec_next;
    logic [15:0] utag_reg, utag_next;
    logic        urmv_reg, urmv_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [CW-1:0] pos_reg, pos_next, ins_reg, ins_next;

    logic        ov_reg, ov_next, ol_reg, ol_next;
    logic [2:0]  ok_reg, ok_next;
    logic [79:0] od_reg, od_next;

    // order write port
    logic          ow_en;
    logic [SW-1:0] ow_addr, ow_data;

    logic [SW-1:0] pos_idx, e;
    logic          e_not_after_new, e_not_after_now;
    logic          slot_wr;
    logic [SW-1:0] free_slot;
    logic          have_free;

    // input decode
    logic [31:0] in_nsec, in_dsec;
    logic [19:0] in_nusec, in_dusec, usum_c;
    logic [20:0] usum;
    logic [32:0] ssum;
    logic [3:0]  in_handle;

    assign pos_idx = pos_reg[SW-1:0];
    assign e = order_mem[pos_idx];
    assign e_not_after_new = (sec_mem[e] < dsec_reg) ||
                             (sec_mem[e] == dsec_reg && usec_mem[e] <= dusec_reg);
    assign e_not_after_now = (sec_mem[e] < nsec_reg) ||
                             (sec_mem[e] == nsec_reg && usec_mem[e] <= nusec_reg);

    always_comb begin
        have_free = 1'b0;
        free_slot = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (!used_reg[k]) begin
                have_free = 1'b1;
                free_slot = SW'(k);
            end
        end
    end

    assign in_nsec  = s_tdata[33:2];
    assign in_nusec = (s_tdata[53:34] > USEC_MAX) ? USEC_MAX : s_tdata[53:34];
    assign in_dsec  = s_tdata[85:54];
    assign in_dusec = (s_tdata[105:86] > USEC_MAX) ? USEC_MAX : s_tdata[105:86];
    assign in_handle = s_tdata[125:122];
    assign usum = {1'b0, in_nusec} + {1'b0, in_dusec};
    assign usum_c = (usum >= {1'b0, USEC_PER_SEC}) ? 20'(usum - {1'b0, USEC_PER_SEC})
                                                  : usum[19:0];
    assign ssum = {1'b0, in_nsec} + {1'b0, in_dsec} +
                  {32'd0, usum >= {1'b0, USEC_PER_SEC}};

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ok_reg;
    assign m_tlast  = ol_reg;

    function automatic logic [79:0] pack(input logic [SW-1:0] h, input err_t er,
                                         input entry_state_t st, input logic [15:0] tg,
                                         input logic [31:0] sc, input logic [19:0] us,
                                         input logic ar);
        logic [3:0] h4;
        h4 = 4'(h);
        pack = {3'd0, ar, us, sc, tg, st, er, h4};
    endfunction

    always_ff @(posedge aclk) begin
        if (slot_wr) begin
            sec_mem[slot_reg]  <= dsec_reg;
            usec_mem[slot_reg] <= dusec_reg;
            tag_mem[slot_reg]  <= utag_reg;
        end
        if (ow_en) order_mem[ow_addr] <= ow_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            done_reg <= '0;
            rmv_reg <= '0;
            count_reg <= '0;
            armed_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next;
            done_reg <= done_next;
            rmv_reg <= rmv_next;
            count_reg <= count_next;
            armed_reg <= armed_next;
            ov_reg <= ov_next;
        end
        armed_slot_reg <= armed_slot_next;
        op_reg <= op_next;
        nsec_reg <= nsec_next;
        nusec_reg <= nusec_next;
        dsec_reg <= dsec_next;
        dusec_reg <= dusec_next;
        utag_reg <= utag_next;
        urmv_reg <= urmv_next;
        slot_reg <= slot_next;
        pos_reg <= pos_next;
        ins_reg <= ins_next;
        ol_reg <= ol_next;
        ok_reg <= ok_next;
        od_reg <= od_next;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && !ov_reg) begin
                    case (op_t'(s_tdata[1:0]))
                        OP_INSERT: begin
                            if (count_reg >= DEPTH_C || !have_free) state_next = S_OUT;
                            else state_next = S_INS_FIND;
                        end
                        OP_REMOVE: begin
                            if ({28'd0, in_handle} >= 32'(QUEUE_DEPTH) ||
                                !used_reg[SW'(in_handle)]) state_next = S_OUT;
                            else state_next = S_REM_FIND;
                        end
                        OP_TICK: state_next = S_TICK_SCAN;
                        OP_LIST: state_next = (count_reg == '0) ? S_IDLE : S_LIST;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_FIND: begin
                if (pos_reg == count_reg || !e_not_after_new) state_next = S_INS_SHIFT;
            end
            S_INS_SHIFT: begin
                if (pos_reg == ins_reg) state_next = S_INS_ARM;
            end
            S_INS_ARM: begin
                if (pos_reg == count_reg ||
                    (!done_reg[e] && !e_not_after_now)) state_next = S_OUT;
            end
            S_REM_FIND: begin
                if (e == slot_reg) state_next = S_REM_SHIFT;
            end
            S_REM_SHIFT: begin
                if (pos_reg + 1'b1 >= count_reg) state_next = S_OUT;
            end
            S_TICK_SCAN: begin
                if (!(ov_reg && !m_tready)) begin
                    if (pos_reg == count_reg) state_next = S_TICK_ARM;
                    else if (!done_reg[e] && e_not_after_now && rmv_reg[e])
                        state_next = S_TICK_SHIFT;
                end
            end
            S_TICK_SHIFT: begin
                if (pos_reg + 1'b1 >= count_reg) state_next = S_TICK_SCAN;
            end
            S_TICK_ARM: begin
                if (!(ov_reg && !m_tready) &&
                    (pos_reg == count_reg || !done_reg[e])) state_next = S_OUT;
            end
            S_LIST: begin
                if (!(ov_reg && !m_tready) && pos_reg + 1'b1 == count_reg)
                    state_next = S_OUT;
            end
            S_OUT: begin
                if (!(ov_reg && !m_tready)) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        used_next = used_reg;
        done_next = done_reg;
        rmv_next = rmv_reg;
        count_next = count_reg;
        armed_next = armed_reg;
        armed_slot_next = armed_slot_reg;
        op_next = op_reg;
        nsec_next = nsec_reg;
        nusec_next = nusec_reg;
        dsec_next = dsec_reg;
        dusec_next = dusec_reg;
        utag_next = utag_reg;
        urmv_next = urmv_reg;
        slot_next = slot_reg;
        pos_next = pos_reg;
        ins_next = ins_reg;
        ov_next = ov_reg && !m_tready;
        ol_next = ol_reg;
        ok_next = ok_reg;
        od_next = od_reg;
        ow_en = 1'b0;
        ow_addr = pos_idx;
        ow_data = '0;
        slot_wr = 1'b0;
        case (state_reg)
            S_IDLE: begin
                pos_next = '0;
                if (s_tvalid && !ov_reg) begin
                    op_next = op_t'(s_tdata[1:0]);
                    nsec_next = in_nsec;
                    nusec_next = in_nusec;
                    utag_next = s_tdata[121:106];
                    urmv_next = s_tuser;
                    slot_next = free_slot;
                    dsec_next = ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
                    dusec_next = ssum[32] ? USEC_MAX : usum_c;
                    ol_next = 1'b1;
                    case (op_t'(s_tdata[1:0]))
                        OP_INSERT: begin
                            ok_next = KIND_INSERT;
                            od_next = pack('0, ERR_FULL, ST_SCHEDULED, '0, '0, '0, 1'b0);
                        end
                        OP_REMOVE: begin
                            slot_next = SW'(in_handle);
                            ok_next = KIND_REMOVE;
                            od_next = {3'd0, 1'b0, 20'd0, 32'd0, 16'd0,
                                       ST_SCHEDULED, ERR_BAD, in_handle};
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_FIND: begin
                if (pos_reg == count_reg || !e_not_after_new) begin
                    ins_next = pos_reg;
                    pos_next = count_reg;
                    slot_wr = 1'b1;
                    used_next[slot_reg] = 1'b1;
                    done_next[slot_reg] = 1'b0;
                    rmv_next[slot_reg] = urmv_reg;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_INS_SHIFT: begin
                ow_en = 1'b1;
                if (pos_reg == ins_reg) begin
                    ow_data = slot_reg;
                    count_next = count_reg + 1'b1;
                    pos_next = '0;
                    armed_next = 1'b0;
                end else begin
                    ow_data = order_mem[SW'(pos_reg - 1'b1)];
                    pos_next = pos_reg - 1'b1;
                end
            end
            S_INS_ARM: begin
                if (pos_reg != count_reg && !done_reg[e] && !e_not_after_now) begin
                    armed_next = 1'b1;
                    armed_slot_next = e;
                end
                pos_next = pos_reg + 1'b1;
                ok_next = KIND_INSERT;
                od_next = pack(slot_reg, ERR_OK, ST_SCHEDULED, utag_reg,
                               dsec_reg, dusec_reg, 1'b0);
                if (state_next == S_OUT) ov_next = 1'b0;
            end
            S_REM_FIND: begin
                if (e == slot_reg) begin
                    ok_next = KIND_REMOVE;
                    od_next = pack(slot_reg, ERR_OK, ST_SCHEDULED, tag_mem[slot_reg],
                                   sec_mem[slot_reg], usec_mem[slot_reg], 1'b0);
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_REM_SHIFT, S_TICK_SHIFT: begin
                if (pos_reg + 1'b1 >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    used_next[slot_reg] = 1'b0;
                    done_next[slot_reg] = 1'b0;
                    rmv_next[slot_reg] = 1'b0;
                    if (armed_reg && armed_slot_reg == slot_reg) armed_next = 1'b0;
                end else begin
                    ow_en = 1'b1;
                    ow_data = order_mem[SW'(pos_reg + 1'b1)];
                    pos_next = pos_reg + 1'b1;
                end
                if (state_reg == S_TICK_SHIFT && pos_reg + 1'b1 >= count_reg)
                    pos_next = ins_reg;
            end
            S_TICK_SCAN: begin
                if (!(ov_reg && !m_tready)) begin
                    if (pos_reg == count_reg) begin
                        pos_next = '0;
                    end else if (!done_reg[e] && e_not_after_now) begin
                        ov_next = 1'b1;
                        ol_next = 1'b0;
                        ok_next = KIND_FIRED;
                        od_next = pack(e, ERR_OK, ST_SCHEDULED, tag_mem[e],
                                       sec_mem[e], usec_mem[e], 1'b0);
                        if (rmv_reg[e]) begin
                            slot_next = e;
                            ins_next = pos_reg;
                        end else begin
                            done_next[e] = 1'b1;
                            if (armed_reg && armed_slot_reg == e) armed_next = 1'b0;
                            pos_next = pos_reg + 1'b1;
                        end
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            S_TICK_ARM: begin
                if (!(ov_reg && !m_tready)) begin
                    ok_next = KIND_REPORT;
                    ol_next = 1'b1;
                    if (pos_reg == count_reg) begin
                        armed_next = 1'b0;
                        od_next = pack('0, ERR_OK, ST_SCHEDULED, '0, '0, '0, 1'b0);
                    end else if (!done_reg[e]) begin
                        armed_next = 1'b1;
                        armed_slot_next = e;
                        od_next = pack(e, ERR_OK, ST_SCHEDULED, tag_mem[e],
                                       sec_mem[e], usec_mem[e], 1'b1);
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            S_LIST: begin
                if (!(ov_reg && !m_tready)) begin
                    ov_next = 1'b1;
                    ok_next = KIND_LIST;
                    ol_next = (pos_reg + 1'b1 == count_reg);
                    od_next = pack(e, ERR_OK,
                                   done_reg[e] ? ST_DONE :
                                   ((armed_reg && armed_slot_reg == e) ? ST_NEXT
                                                                       : ST_SCHEDULED),
                                   tag_mem[e], sec_mem[e], usec_mem[e], 1'b0);
                    pos_next = pos_reg + 1'b1;
                    if (ol_next) ov_next = 1'b1;
                end
            end
            S_OUT: begin
                if (!(ov_reg && !m_tready)) begin
                    if (op_reg == OP_LIST) ov_next = 1'b0;
                    else ov_next = 1'b1;
                    ol_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/dstq_checker.sv =====
module dstq_checker
    import dstq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= 3'd4)
        else $error("unknown result kind");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_INSERT || m_tuser == KIND_REMOVE ||
                     m_tuser == KIND_REPORT) |-> m_tlast)
        else $error("single-word reply without last");

    a_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_FIRED |-> !m_tlast && m_tdata[5:4] == ERR_OK)
        else $error("fired word malformed");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid)
        else $error("command word taken while a result word was waiting");

endmodule

bind deadline_sorted_timer_queue dstq_checker u_dstq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
);
